// ----- src/nsps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsps_pkg
// Shared widths, codes, unit handshake types and coordinate helpers for the
// nearest segment point search core.
// ----------------------------------------------------------------------------
package nsps_pkg;

    localparam int COORD_BITS       = 16;
    localparam int LABEL_BITS       = 16;
    localparam int DIST_BITS        = 17;
    localparam int SEG_W            = 4 * COORD_BITS;
    localparam int MAX_SEGMENTS_DEF = 1024;

    // divide / root unit widths
    localparam int DVD_W  = 68;   // dividend, 4*c^2 at most
    localparam int DEN_W  = 35;   // divisor, 2*|b-a|^2 at most
    localparam int REM_W  = DEN_W + 1;
    localparam int QUO_W  = 38;   // quotient and root operand
    localparam int ROOT_W = QUO_W / 2;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic {DU_DIV, DU_SQRT} t_du_mode;

    typedef struct packed {
        logic               start;
        t_du_mode           mode;
        logic [DVD_W-1:0]   dividend;
        logic [DEN_W-1:0]   divisor;
    } t_du_req;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quo;
        logic               rem_nz;
        logic [ROOT_W-1:0]  root;
    } t_du_rsp;

    typedef struct packed {
        logic               neg;
        logic [DVD_W-1:0]   mag;
    } t_num;

    // numerator 2*d*t + l2 as sign and magnitude; m = |d|*t
    function automatic t_num coord_num(input logic dneg, input logic [49:0] m,
                                       input logic [34:0] l2);
        t_num        res;
        logic [51:0] m2;
        logic [51:0] l2w;
        m2  = 52'({m, 1'b0});
        l2w = 52'(l2);
        if (!dneg) begin
            res.neg = 1'b0;
            res.mag = DVD_W'(m2 + l2w);
        end else if (m2 > l2w) begin
            res.neg = 1'b1;
            res.mag = DVD_W'(m2 - l2w);
        end else begin
            res.neg = 1'b0;
            res.mag = DVD_W'(l2w - m2);
        end
        return res;
    endfunction

    // floor quotient plus start coordinate, then truncate toward zero
    function automatic logic [COORD_BITS-1:0] coord_fix(
        input logic signed [COORD_BITS-1:0] a, input logic neg,
        input logic [17:0] q, input logic nz);
        logic signed [19:0] qs;
        logic signed [19:0] f;
        logic signed [19:0] r;
        qs = neg ? -($signed({2'b00, q}) + $signed({19'b0, nz}))
                 : $signed({2'b00, q});
        f  = {{(20-COORD_BITS){a[COORD_BITS-1]}}, a} + qs;
        r  = f + $signed({19'b0, f[19] & nz});
        return r[COORD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/nsps_seg_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsps_seg_mem
// Segment coordinate and tag storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsps_seg_mem
    import nsps_pkg::*;
#(
    parameter int DEPTH = MAX_SEGMENTS_DEF,
    parameter int AW    = 10,
    parameter int TW    = 26
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [SEG_W-1:0] i_wcoord,
    input  wire logic [TW-1:0]    i_wtag,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [SEG_W-1:0] o_rcoord,
    output logic      [TW-1:0]    o_rtag
);

    logic [SEG_W-1:0] coords [DEPTH];
    logic [TW-1:0]    tags   [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            coords[i_waddr] <= i_wcoord;
            tags[i_waddr]   <= i_wtag;
        end
        o_rcoord <= coords[i_raddr];
        o_rtag   <= tags[i_raddr];
    end

endmodule
`default_nettype wire

// ----- src/nsps_divsqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsps_divsqrt
// Shared iterative unit: restoring divide, one quotient bit a cycle, or
// integer square root, one root bit a cycle.
// ----------------------------------------------------------------------------
module nsps_divsqrt
    import nsps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_du_req i_req,
    output t_du_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    t_du_mode          r_mode;
    logic [5:0]        r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_sh;
    logic [ROOT_W-1:0] r_root;
    logic [DEN_W-1:0]  r_den;

    logic [REM_W-1:0]  div_trial;
    logic              div_ge;
    logic [REM_W-1:0]  sq_trem;
    logic [REM_W-1:0]  sq_trial;
    logic              sq_ge;

    assign div_trial = {r_rem[REM_W-2:0], r_sh[QUO_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_den};
    assign sq_trem   = {r_rem[REM_W-3:0], r_sh[QUO_W-1 -: 2]};
    assign sq_trial  = REM_W'({r_root, 2'b01});
    assign sq_ge     = sq_trem >= sq_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_den  <= i_req.divisor;
                r_sh   <= i_req.dividend[QUO_W-1:0];
                r_root <= '0;
                if (i_req.mode == DU_DIV) begin
                    r_rem <= REM_W'(i_req.dividend[DVD_W-1:QUO_W]);
                    r_cnt <= 6'(QUO_W);
                end else begin
                    r_rem <= '0;
                    r_cnt <= 6'(ROOT_W);
                end
            end else if (r_busy) begin
                if (r_mode == DU_DIV) begin
                    r_rem <= div_ge ? div_trial - {1'b0, r_den} : div_trial;
                    r_sh  <= {r_sh[QUO_W-2:0], div_ge};
                end else begin
                    r_rem  <= sq_ge ? sq_trem - sq_trial : sq_trem;
                    r_sh   <= {r_sh[QUO_W-3:0], 2'b00};
                    r_root <= {r_root[ROOT_W-2:0], sq_ge};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quo    = r_sh;
    assign o_rsp.rem_nz = r_rem != '0;
    assign o_rsp.root   = r_root;

endmodule
`default_nettype wire

// ----- src/nearest_segment_point_search_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_segment_point_search_core
// Stores labeled 2D segments and finds the closest point on them to a query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one command per transfer: clear,
//   load one segment, or query a point. Output channel o_valid/i_ready
//   returns exactly one result per command, in order.
//   Clear and load pass from the transfer through S_PUT to the result register.
//   A query scans all stored segments one at a time through the segment
//   memory (one read a cycle, registered), a shared 18x18 multiplier
//   and a shared bit-serial divide/root unit: an endpoint-nearest segment
//   takes one root, a projection-nearest segment three divides and one
//   root, so query time for N segments is set by these divide (38 quotient
//   bits) and root (19 bits) loops.
//   The input side is ready whenever the sequencer is idle; a finished
//   result waits in the output register, so one new command can be taken
//   while the receiver stalls. A second result then waits until the first
//   transfers.
//   Reset empties the store (count and geometry number) and drops any
//   result; memory contents are not cleared and are never read unwritten.
// ----------------------------------------------------------------------------
module nearest_segment_point_search_core
    import nsps_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_action,
    input  wire logic signed [COORD_BITS-1:0] i_point_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic [LABEL_BITS-1:0]        i_label,
    input  wire logic                         i_starts_geometry,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [COORD_BITS-1:0]      o_nearest_x,
    output logic signed [COORD_BITS-1:0]      o_nearest_y,
    output logic [LABEL_BITS-1:0]             o_nearest_label,
    output logic [DIST_BITS-1:0]              o_distance,
    output logic [1:0]                        o_status
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int TW = LABEL_BITS + AW;

    typedef enum logic [3:0] {
        S_IDLE, S_PUT, S_RD, S_DIFF, S_MULB, S_CASE, S_MULE, S_MULP,
        S_DIVC, S_SQRT, S_DIVX, S_DIVY, S_UPD, S_FIN
    } t_state;

    t_state r_state;

    // store bookkeeping
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_geo;
    logic [CW-1:0] r_idx;

    // current segment
    logic signed [15:0] r_px, r_py, r_ax, r_ay, r_bx, r_by;
    logic signed [16:0] r_dx, r_dy, r_ex, r_ey, r_fx, r_fy, r_ux, r_uy;
    logic signed [35:0] r_prod, r_l2, r_t, r_c, r_s;
    logic [2:0]         r_k, r_pk;
    logic               r_pv;
    logic [33:0]        r_cabs;
    logic [67:0]        r_n;
    logic [49:0]        r_mx, r_my;
    logic               r_proj, r_neg;
    logic [DIST_BITS-1:0] r_d;
    logic [15:0]        r_qx, r_qy;

    // per geometry and overall best
    logic                  r_geo_ok, r_all_ok;
    logic [DIST_BITS-1:0]  r_geo_d, r_best_d;
    logic [15:0]           r_gx, r_gy, r_best_x, r_best_y;
    logic [LABEL_BITS-1:0] r_geo_l, r_best_l;
    logic [AW-1:0]         r_cur_geo;

    // pending result and output register
    logic [15:0]           r_res_x, r_res_y;
    logic [LABEL_BITS-1:0] r_res_l;
    logic [DIST_BITS-1:0]  r_res_d;
    logic [1:0]            r_res_st;
    logic                  r_o_valid;
    logic [15:0]           r_o_x, r_o_y;
    logic [LABEL_BITS-1:0] r_o_l;
    logic [DIST_BITS-1:0]  r_o_d;
    logic [1:0]            r_o_st;

    // divide/root launch
    logic             r_launch;
    t_du_mode         r_req_mode;
    logic [DVD_W-1:0] r_req_dvd;
    logic [DEN_W-1:0] r_req_den;
    t_du_req          du_req;
    t_du_rsp          du_rsp;

    logic               accept, full, mem_we;
    logic [AW-1:0]      n_geo;
    logic [SEG_W-1:0]   rd_coord;
    logic [TW-1:0]      rd_tag;
    logic signed [17:0] m_a, m_b;
    logic               take;
    t_num               num_x, num_y;
    logic [19:0]        root_inc;
    logic [AW-1:0]      tag_geo;
    logic signed [15:0] t_ax, t_ay, t_bx, t_by;

    assign o_ready = (r_state == S_IDLE) && i_rst_n;
    assign accept  = i_valid && o_ready;
    assign full    = r_count >= CW'(MAX_SEGMENTS);
    assign mem_we  = accept && (i_action == ACT_LOAD) && !full;
    assign n_geo   = (r_count != '0 && i_starts_geometry) ? r_geo + AW'(1) : r_geo;

    nsps_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW),
        .TW    (TW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (r_count[AW-1:0]),
        .i_wcoord ({i_end_y, i_end_x, i_point_y, i_point_x}),
        .i_wtag   ({n_geo, i_label}),
        .i_raddr  (r_idx[AW-1:0]),
        .o_rcoord (rd_coord),
        .o_rtag   (rd_tag)
    );

    assign du_req.start    = r_launch;
    assign du_req.mode     = r_req_mode;
    assign du_req.dividend = r_req_dvd;
    assign du_req.divisor  = r_req_den;

    nsps_divsqrt u_du (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .o_rsp   (du_rsp)
    );

    assign t_ax    = rd_coord[15:0];
    assign t_ay    = rd_coord[31:16];
    assign t_bx    = rd_coord[47:32];
    assign t_by    = rd_coord[63:48];
    assign tag_geo = rd_tag[TW-1:LABEL_BITS];

    // a finished geometry beats the best only with a strictly smaller distance
    assign take     = r_geo_ok && (!r_all_ok || r_geo_d < r_best_d);
    assign num_x    = coord_num(r_dx[16], r_mx, r_l2[34:0]);
    assign num_y    = coord_num(r_dy[16], r_my, r_l2[34:0]);
    assign root_inc = 20'(du_rsp.root) + 20'd1;

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_MULB: begin
                case (r_k)
                    3'd0: begin m_a = {r_dx[16], r_dx}; m_b = {r_dx[16], r_dx}; end
                    3'd1: begin m_a = {r_dy[16], r_dy}; m_b = {r_dy[16], r_dy}; end
                    3'd2: begin m_a = {r_ex[16], r_ex}; m_b = {r_dx[16], r_dx}; end
                    3'd3: begin m_a = {r_ey[16], r_ey}; m_b = {r_dy[16], r_dy}; end
                    3'd4: begin m_a = {r_ex[16], r_ex}; m_b = {r_dy[16], r_dy}; end
                    3'd5: begin m_a = {r_ey[16], r_ey}; m_b = {r_dx[16], r_dx}; end
                    default: ;
                endcase
            end
            S_MULE: begin
                case (r_k)
                    3'd0: begin m_a = {r_ux[16], r_ux}; m_b = {r_ux[16], r_ux}; end
                    3'd1: begin m_a = {r_uy[16], r_uy}; m_b = {r_uy[16], r_uy}; end
                    default: ;
                endcase
            end
            S_MULP: begin
                // |c| and t split into 17-bit halves
                case (r_k)
                    3'd0: begin m_a = {1'b0, r_cabs[33:17]}; m_b = {1'b0, r_cabs[33:17]}; end
                    3'd1: begin m_a = {1'b0, r_cabs[33:17]}; m_b = {1'b0, r_cabs[16:0]}; end
                    3'd2: begin m_a = {1'b0, r_cabs[16:0]};  m_b = {1'b0, r_cabs[16:0]}; end
                    3'd3: begin
                        m_a = {1'b0, r_dx[16] ? -r_dx : r_dx}; m_b = {1'b0, r_t[33:17]};
                    end
                    3'd4: begin
                        m_a = {1'b0, r_dx[16] ? -r_dx : r_dx}; m_b = {1'b0, r_t[16:0]};
                    end
                    3'd5: begin
                        m_a = {1'b0, r_dy[16] ? -r_dy : r_dy}; m_b = {1'b0, r_t[33:17]};
                    end
                    3'd6: begin
                        m_a = {1'b0, r_dy[16] ? -r_dy : r_dy}; m_b = {1'b0, r_t[16:0]};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_geo     <= '0;
            r_o_valid <= 1'b0;
            r_launch  <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            // multiplier pipe: product registered, then accumulated in the following cycle
            r_prod <= m_a * m_b;
            if (r_pv) begin
                case (r_state)
                    S_MULB: begin
                        case (r_pk)
                            3'd0: r_l2 <= r_prod;
                            3'd1: r_l2 <= r_l2 + r_prod;
                            3'd2: r_t  <= r_prod;
                            3'd3: r_t  <= r_t + r_prod;
                            3'd4: r_c  <= r_prod;
                            3'd5: r_c  <= r_c - r_prod;
                            default: ;
                        endcase
                    end
                    S_MULE: begin
                        case (r_pk)
                            3'd0: r_s <= r_prod;
                            3'd1: r_s <= r_s + r_prod;
                            default: ;
                        endcase
                    end
                    S_MULP: begin
                        case (r_pk)
                            3'd0: r_n  <= {r_prod[31:0], 36'b0};
                            3'd1: r_n  <= r_n + {14'b0, r_prod[33:0], 20'b0};
                            3'd2: r_n  <= r_n + {32'b0, r_prod[33:0], 2'b0};
                            3'd3: r_mx <= {r_prod[32:0], 17'b0};
                            3'd4: r_mx <= r_mx + {16'b0, r_prod[33:0]};
                            3'd5: r_my <= {r_prod[32:0], 17'b0};
                            3'd6: r_my <= r_my + {16'b0, r_prod[33:0]};
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_x  <= '0;
                        r_res_y  <= '0;
                        r_res_l  <= '0;
                        r_res_d  <= '0;
                        r_res_st <= ST_OK;
                        r_state  <= S_PUT;
                        case (i_action)
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_geo   <= '0;
                            end
                            ACT_LOAD: begin
                                if (full) begin
                                    r_res_st <= ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    r_geo   <= n_geo;
                                end
                            end
                            ACT_QUERY: begin
                                if (r_count == '0) begin
                                    r_res_st <= ST_EMPTY;
                                end else begin
                                    r_px     <= i_point_x;
                                    r_py     <= i_point_y;
                                    r_idx    <= '0;
                                    r_geo_ok <= 1'b0;
                                    r_all_ok <= 1'b0;
                                    r_state  <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_x     <= r_res_x;
                        r_o_y     <= r_res_y;
                        r_o_l     <= r_res_l;
                        r_o_d     <= r_res_d;
                        r_o_st    <= r_res_st;
                        r_state   <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_ax <= t_ax;
                    r_ay <= t_ay;
                    r_bx <= t_bx;
                    r_by <= t_by;
                    r_dx <= {t_bx[15], t_bx} - {t_ax[15], t_ax};
                    r_dy <= {t_by[15], t_by} - {t_ay[15], t_ay};
                    r_ex <= {r_px[15], r_px} - {t_ax[15], t_ax};
                    r_ey <= {r_py[15], r_py} - {t_ay[15], t_ay};
                    r_fx <= {r_px[15], r_px} - {t_bx[15], t_bx};
                    r_fy <= {r_py[15], r_py} - {t_by[15], t_by};
                    // geometry boundary: close out the previous geometry
                    if (r_idx == '0 || tag_geo != r_cur_geo) begin
                        if (take) begin
                            r_all_ok <= 1'b1;
                            r_best_d <= r_geo_d;
                            r_best_x <= r_gx;
                            r_best_y <= r_gy;
                            r_best_l <= r_geo_l;
                        end
                        r_geo_ok  <= 1'b0;
                        r_cur_geo <= tag_geo;
                        r_geo_l   <= rd_tag[LABEL_BITS-1:0];
                    end
                    r_k     <= '0;
                    r_state <= S_MULB;
                end
                S_MULB, S_MULE, S_MULP: begin
                    if ((r_state == S_MULB && r_k != 3'd6) ||
                        (r_state == S_MULE && r_k != 3'd2) ||
                        (r_state == S_MULP && r_k != 3'd7)) begin
                        r_pv <= 1'b1;
                        r_pk <= r_k;
                        r_k  <= r_k + 3'd1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_k <= '0;
                            case (r_state)
                                S_MULB: r_state <= S_CASE;
                                S_MULE: begin
                                    // endpoint: root of 4*s
                                    r_req_mode <= DU_SQRT;
                                    r_req_dvd  <= DVD_W'({r_s[35:0], 2'b00});
                                    r_launch   <= 1'b1;
                                    r_state    <= S_SQRT;
                                end
                                default: begin
                                    r_req_mode <= DU_DIV;
                                    r_req_dvd  <= r_n;
                                    r_req_den  <= DEN_W'(r_l2[34:0]);
                                    r_launch   <= 1'b1;
                                    r_state    <= S_DIVC;
                                end
                            endcase
                        end
                    end
                end
                S_CASE: begin
                    if (r_l2 == '0 || r_t[35]) begin
                        r_proj  <= 1'b0;
                        r_ux    <= r_ex;
                        r_uy    <= r_ey;
                        r_qx    <= r_ax;
                        r_qy    <= r_ay;
                        r_state <= S_MULE;
                    end else if (r_t > r_l2) begin
                        r_proj  <= 1'b0;
                        r_ux    <= r_fx;
                        r_uy    <= r_fy;
                        r_qx    <= r_bx;
                        r_qy    <= r_by;
                        r_state <= S_MULE;
                    end else begin
                        r_proj  <= 1'b1;
                        r_cabs  <= r_c[35] ? 34'(-r_c) : r_c[33:0];
                        r_state <= S_MULP;
                    end
                end
                S_DIVC: begin
                    if (du_rsp.done) begin
                        r_req_mode <= DU_SQRT;
                        r_req_dvd  <= DVD_W'(du_rsp.quo);
                        r_launch   <= 1'b1;
                        r_state    <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (du_rsp.done) begin
                        r_d <= root_inc[DIST_BITS:1];
                        if (r_proj) begin
                            r_req_mode <= DU_DIV;
                            r_req_dvd  <= num_x.mag;
                            r_req_den  <= {r_l2[33:0], 1'b0};
                            r_neg      <= num_x.neg;
                            r_launch   <= 1'b1;
                            r_state    <= S_DIVX;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_DIVX: begin
                    if (du_rsp.done) begin
                        r_qx       <= coord_fix(r_ax, r_neg, du_rsp.quo[17:0], du_rsp.rem_nz);
                        r_req_dvd  <= num_y.mag;
                        r_neg      <= num_y.neg;
                        r_launch   <= 1'b1;
                        r_state    <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (du_rsp.done) begin
                        r_qy    <= coord_fix(r_ay, r_neg, du_rsp.quo[17:0], du_rsp.rem_nz);
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    // within a geometry a later equal distance wins
                    if (!r_geo_ok || r_d <= r_geo_d) begin
                        r_geo_ok <= 1'b1;
                        r_geo_d  <= r_d;
                        r_gx     <= r_qx;
                        r_gy     <= r_qy;
                    end
                    if (r_idx + CW'(1) == r_count) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    r_res_st <= ST_OK;
                    r_res_d  <= take ? r_geo_d : r_best_d;
                    r_res_x  <= take ? r_gx : r_best_x;
                    r_res_y  <= take ? r_gy : r_best_y;
                    r_res_l  <= take ? r_geo_l : r_best_l;
                    r_state  <= S_PUT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_nearest_x     = r_o_x;
    assign o_nearest_y     = r_o_y;
    assign o_nearest_label = r_o_l;
    assign o_distance      = r_o_d;
    assign o_status        = r_o_st;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENTS))
        else $error("segment count beyond store depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_distance == '0 && o_nearest_label == '0))
        else $error("error result carries nonzero fields");

    a_du_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        du_rsp.done |-> (r_state == S_DIVC || r_state == S_SQRT ||
                         r_state == S_DIVX || r_state == S_DIVY))
        else $error("divide/root unit finished with no waiting step");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_idx < r_count))
        else $error("scan reads beyond stored segments");

endmodule
`default_nettype wire

// ----- tb/sv/nsps_checker.sv -----
// ----------------------------------------------------------------------------
// nsps_checker
// Watches both channels of the nearest segment point search core, keeps its
// own copy of the segment store, predicts each result and compares it.
// ----------------------------------------------------------------------------
module nsps_checker
    import nsps_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire logic                         i_cmd_ready,
    input  wire logic [1:0]                   i_action,
    input  wire logic signed [COORD_BITS-1:0] i_point_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic [LABEL_BITS-1:0]        i_label,
    input  wire logic                         i_starts_geometry,
    input  wire logic                         i_res_valid,
    input  wire logic                         i_res_ready,
    input  wire logic signed [COORD_BITS-1:0] i_nearest_x,
    input  wire logic signed [COORD_BITS-1:0] i_nearest_y,
    input  wire logic [LABEL_BITS-1:0]        i_nearest_label,
    input  wire logic [DIST_BITS-1:0]         i_distance,
    input  wire logic [1:0]                   i_status,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int STORE_DEPTH = MAX_SEGMENTS_DEF;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [LABEL_BITS-1:0]        label;
        logic [DIST_BITS-1:0]         dval;
        logic [1:0]                   status;
    } nearest_t;

    // local copy of the segment store
    longint          seg_ax [STORE_DEPTH];
    longint          seg_ay [STORE_DEPTH];
    longint          seg_bx [STORE_DEPTH];
    longint          seg_by [STORE_DEPTH];
    int unsigned     seg_geo [STORE_DEPTH];
    logic [LABEL_BITS-1:0] seg_label [STORE_DEPTH];
    int unsigned     seg_count;
    int unsigned     geo_num;

    nearest_t        expected_q[$];

    // largest n >= 0 with (2n-1)^2 * den <= m1 * m2
    function automatic longint half_up_root(logic [127:0] m1, logic [127:0] m2,
                                            logic [127:0] den);
        logic [127:0] prod;
        logic [127:0] k;
        longint       lo;
        longint       hi;
        longint       mid;
        prod = m1 * m2;
        lo   = 0;
        hi   = 64'd1 << 18;
        while (hi - lo > 1) begin
            mid = lo + ((hi - lo) >> 1);
            k   = 128'(2 * mid - 1);
            if (k * k * den <= prod) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic longint corner_dist(longint ex, longint ey);
        return half_up_root(128'(4 * (ex * ex + ey * ey)), 128'd1, 128'd1);
    endfunction

    // closest point of one stored segment to (px, py)
    function automatic void closest_on_segment(int unsigned i, longint px, longint py,
                                               output longint d, output longint qx,
                                               output longint qy);
        longint dx, dy, ex, ey, l2, t, c;
        dx = seg_bx[i] - seg_ax[i];
        dy = seg_by[i] - seg_ay[i];
        ex = px - seg_ax[i];
        ey = py - seg_ay[i];
        l2 = dx * dx + dy * dy;
        t  = ex * dx + ey * dy;
        if (l2 == 0 || t < 0) begin
            d = corner_dist(ex, ey); qx = seg_ax[i]; qy = seg_ay[i];
        end else if (t > l2) begin
            d = corner_dist(px - seg_bx[i], py - seg_by[i]); qx = seg_bx[i]; qy = seg_by[i];
        end else begin
            c = ex * dy - ey * dx;
            if (c < 0) c = -c;
            d  = half_up_root(128'(2 * c), 128'(2 * c), 128'(l2));
            // SV division truncates toward zero, which is the rounding wanted
            qx = (2 * (seg_ax[i] * l2 + dx * t) + l2) / (2 * l2);
            qy = (2 * (seg_ay[i] * l2 + dy * t) + l2) / (2 * l2);
        end
    endfunction

    function automatic nearest_t nearest_over_store(longint px, longint py);
        nearest_t    r;
        bit          all_ok, geo_ok;
        longint      best_d, geo_d, gx, gy, d, qx, qy;
        int unsigned cur_geo;
        logic [LABEL_BITS-1:0] geo_l, best_l;
        r = '{x: '0, y: '0, label: '0, dval: '0, status: ST_OK};
        all_ok = 0; geo_ok = 0; best_d = 0; geo_d = 0; gx = 0; gy = 0;
        cur_geo = 0; geo_l = '0; best_l = '0;
        for (int unsigned i = 0; i < seg_count; i++) begin
            if (i == 0 || seg_geo[i] != cur_geo) begin
                // close the previous geometry: earlier geometry wins a tie
                if (geo_ok && (!all_ok || geo_d < best_d)) begin
                    all_ok = 1; best_d = geo_d; best_l = geo_l;
                    r.x = COORD_BITS'(gx); r.y = COORD_BITS'(gy);
                end
                geo_ok  = 0;
                cur_geo = seg_geo[i];
                geo_l   = seg_label[i];
            end
            closest_on_segment(i, px, py, d, qx, qy);
            // later segment wins a tie inside a geometry
            if (!geo_ok || d <= geo_d) begin
                geo_ok = 1; geo_d = d; gx = qx; gy = qy;
            end
        end
        if (geo_ok && (!all_ok || geo_d < best_d)) begin
            best_d = geo_d; best_l = geo_l;
            r.x = COORD_BITS'(gx); r.y = COORD_BITS'(gy);
        end
        r.label = best_l;
        r.dval  = DIST_BITS'(best_d);
        return r;
    endfunction

    function automatic nearest_t apply_command();
        nearest_t r;
        r = '{x: '0, y: '0, label: '0, dval: '0, status: ST_OK};
        case (i_action)
            ACT_CLEAR: begin
                seg_count = 0;
                geo_num   = 0;
            end
            ACT_LOAD: begin
                if (seg_count >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (seg_count > 0 && i_starts_geometry) geo_num++;
                    seg_ax[seg_count]    = i_point_x;
                    seg_ay[seg_count]    = i_point_y;
                    seg_bx[seg_count]    = i_end_x;
                    seg_by[seg_count]    = i_end_y;
                    seg_label[seg_count] = i_label;
                    seg_geo[seg_count]   = geo_num;
                    seg_count++;
                end
            end
            ACT_QUERY: begin
                if (seg_count == 0) r.status = ST_EMPTY;
                else r = nearest_over_store(i_point_x, i_point_y);
            end
            default: ;  // unused code answers ok and changes nothing
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        nearest_t want;
        if (!i_rst_n) begin
            seg_count     = 0;
            geo_num       = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
            expected_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result transfer with nothing expected", $time);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (i_nearest_x !== want.x || i_nearest_y !== want.y ||
                        i_nearest_label !== want.label || i_distance !== want.dval ||
                        i_status !== want.status) begin
                        if (o_fail_count < 10)
                            $display("%0t: exp x=%0d y=%0d lbl=%0d d=%0d st=%0d, got x=%0d y=%0d lbl=%0d d=%0d st=%0d",
                                     $time, want.x, want.y, want.label, want.dval,
                                     want.status, i_nearest_x, i_nearest_y,
                                     i_nearest_label, i_distance, i_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                want       = apply_command();
                expected_q = {expected_q, want};
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, load and query commands into the nearest segment point search
// core with random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import nsps_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;  // unused code, must be harmless
    localparam int         WATCHDOG  = 500000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [1:0]                   i_action;
    logic signed [COORD_BITS-1:0] i_point_x, i_point_y, i_end_x, i_end_y;
    logic [LABEL_BITS-1:0]        i_label;
    logic                         i_starts_geometry;
    logic                         o_valid;
    logic                         i_ready;
    logic signed [COORD_BITS-1:0] o_nearest_x, o_nearest_y;
    logic [LABEL_BITS-1:0]        o_nearest_label;
    logic [DIST_BITS-1:0]         o_distance;
    logic [1:0]                   o_status;

    int fail_count;
    int pending;
    int sent_count;
    int query_count;
    int idle_cycles;
    bit calm;      // when set, neither side idles

    nearest_segment_point_search_core dut (.*);

    nsps_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (i_valid),
        .i_cmd_ready      (o_ready),
        .i_action         (i_action),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .i_label          (i_label),
        .i_starts_geometry(i_starts_geometry),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_nearest_x      (o_nearest_x),
        .i_nearest_y      (o_nearest_y),
        .i_nearest_label  (o_nearest_label),
        .i_distance       (o_distance),
        .i_status         (o_status),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog: cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // coordinates: extremes, a small window around zero, or anything
    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 6))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2, 3, 4: return COORD_BITS'($urandom_range(0, 200)) - 16'sd100;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // receiver: stalls a random number of cycles before each result
    initial begin
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // one command transfer; valid stays high across back-to-back commands
    task automatic issue(input logic [1:0] act,
                         input logic signed [COORD_BITS-1:0] px, py, ex, ey,
                         input logic [LABEL_BITS-1:0] lab, input logic sg);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_action          <= act;
        i_point_x         <= px;
        i_point_y         <= py;
        i_end_x           <= ex;
        i_end_y           <= ey;
        i_label           <= lab;
        i_starts_geometry <= sg;
        do @(posedge i_clk); while (!o_ready);
        sent_count++;
        if (act == ACT_QUERY) query_count++;
    endtask

    task automatic load_seg(input logic signed [COORD_BITS-1:0] ax, ay, bx, by,
                            input logic [LABEL_BITS-1:0] lab, input logic sg);
        issue(ACT_LOAD, ax, ay, bx, by, lab, sg);
    endtask

    // end point and label fields are don't-care on a query; keep them moving
    task automatic query_at(input logic signed [COORD_BITS-1:0] px, py);
        issue(ACT_QUERY, px, py, COORD_BITS'($urandom), COORD_BITS'($urandom),
              LABEL_BITS'($urandom), 1'($urandom));
    endtask

    // sender stays quiet until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int nseg, nq;
        sent_count = 0;
        query_count = 0;
        calm = 1'b0;
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_action          <= ACT_CLEAR;
        i_point_x         <= '0;
        i_point_y         <= '0;
        i_end_x           <= '0;
        i_end_y           <= '0;
        i_label           <= '0;
        i_starts_geometry <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        query_at(16'sd3, -16'sd4);                    // empty store
        issue(ACT_SPARE, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'h1234, 1'b1);
        // first load after a clear starts a geometry even without the flag
        load_seg(16'sd0, 16'sd10, 16'sd10, 16'sd10, 16'hAAAA, 1'b0);
        load_seg(16'sd0, -16'sd10, 16'sd10, -16'sd10, 16'h5555, 1'b0);
        query_at(16'sd5, 16'sd0);                     // tie inside a geometry
        load_seg(16'sd0, 16'sd20, 16'sd10, 16'sd20, 16'h0F0F, 1'b1);
        load_seg(16'sd0, -16'sd20, 16'sd10, -16'sd20, 16'hF0F0, 1'b1);
        query_at(16'sd5, 16'sd0);
        query_at(16'sd5, 16'sd15);                    // tie across geometries
        query_at(-16'sd7, 16'sd10);                   // before the start point
        query_at(16'sd40, -16'sd12);                  // past the end point
        issue(ACT_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0, 1'b0);
        load_seg(16'sd7, -16'sd3, 16'sd7, -16'sd3, 16'hFFFF, 1'b1);  // zero length
        load_seg(16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'h0001, 1'b1);    // half-way rounding
        query_at(16'sd1, 16'sd2);
        query_at(16'sd2, -16'sd1);
        issue(ACT_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0, 1'b0);
        load_seg(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, 16'h8000, 1'b1);
        load_seg(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'h7FFF, 1'b1);
        query_at(16'sd32767, 16'sd32767);
        query_at(-16'sd32768, 16'sd32767);
        query_at(16'sd1234, -16'sd32768);

        // ---- let the pipeline run dry once ----
        drain();

        // ---- random part: mostly small stores built then queried ----
        for (int n = 0; n < 118; n += nseg + nq + 1) begin
            if ($urandom_range(0, 7) == 0) calm = ~calm;
            if (n > 60 && n < 70) drain();
            nseg = $urandom_range(0, 6);
            nq   = $urandom_range(1, 3);
            if ($urandom_range(0, 3) != 0)
                issue(ACT_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), COORD_BITS'($urandom),
                      LABEL_BITS'($urandom), 1'($urandom));
            else
                issue(ACT_SPARE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), COORD_BITS'($urandom),
                      LABEL_BITS'($urandom), 1'($urandom));
            repeat (nseg)
                load_seg(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                         LABEL_BITS'($urandom), 1'($urandom));
            repeat (nq) query_at(pick_coord(), pick_coord());
        end

        @(posedge i_clk);
        i_valid <= 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d commands (%0d queries): directed ties, extremes, zero-length",
                 sent_count, query_count);
        $display("segments, a full drain and random stores under random stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/nsps_pkg.sv
src/nsps_seg_mem.sv
src/nsps_divsqrt.sv
src/nearest_segment_point_search_core.sv
tb/sv/nsps_checker.sv
tb/sv/tb_top.sv
